// ===== sv/pmsfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pmsfa_pkg
// Shared types and constants for the particle-sensor frame accumulator.
// ----------------------------------------------------------------------------
package pmsfa_pkg;

    localparam int FRAME_LEN_DEFAULT = 20;

    localparam int          POS_W     = 5;
    localparam int          DIV_STEPS = 16;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic [POS_W-1:0] PM25_HI_POS = 5'd5;
    localparam logic [POS_W-1:0] PM25_LO_POS = 5'd6;
    localparam logic [POS_W-1:0] PM10_HI_POS = 5'd9;
    localparam logic [POS_W-1:0] PM10_LO_POS = 5'd10;

    localparam logic [1:0] MODE_RX     = 2'd0;
    localparam logic [1:0] MODE_REPORT = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // frame event from the byte framer
    typedef struct packed {
        logic        done;
        logic        ok;
        logic [15:0] pm25;
        logic [15:0] pm10;
    } frame_evt_t;

    // request to the shared divider
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    // divider status
    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_stat_t;

endpackage

// ===== sv/pm_sensor_frame_accumulator.sv =====
// ----------------------------------------------------------------------------
// pm_sensor_frame_accumulator
// Byte framer, checksum check, PM2.5/PM10 totals and averages on report.
// ----------------------------------------------------------------------------
// byte, clear, zero-count report and unused requests: result registered on accept,
//   next request taken while the sink takes that result (a sink stall holds it off)
// report with nonzero count: two 16-step divisions on the shared divider, PM2.5 then PM10,
//   result registered when the second one finishes, next request taken then
// synchronous active-low reset clears framer, state, totals, count and the output valid
module pm_sensor_frame_accumulator
    import pmsfa_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] frame_done, [1] frame_ok, [17:2] pm25_average, [33:18] pm10_average,
    // [49:34] frames_counted, [50] average_valid, [55:51] zero
    output logic [55:0] m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DIV25 = 3'b010,
        ST_DIV10 = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] pm25_tot_reg, pm25_tot_next;
    logic [31:0] pm10_tot_reg, pm10_tot_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] avg25_reg, avg25_next;
    logic        ovalid_reg, ovalid_next;
    logic [55:0] odata_reg, odata_next;

    logic       accept;
    logic [1:0] mode;
    frame_evt_t evt;
    div_req_t   dreq;
    div_stat_t  dstat;

    assign mode     = s_tuser;
    assign s_tready = (state_reg == ST_IDLE) && (!ovalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    pmsfa_framer #(
        .FRAME_LEN (FRAME_LEN)
    ) u_framer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rx_valid (accept && (mode == MODE_RX)),
        .rx_byte  (s_tdata),
        .evt      (evt)
    );

    pmsfa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .stat    (dstat)
    );

    function automatic logic [55:0] pack_result(
        input logic        done,
        input logic        ok,
        input logic [15:0] a25,
        input logic [15:0] a10,
        input logic [15:0] cnt,
        input logic        aval
    );
        pack_result = {5'd0, aval, cnt, a10, a25, ok, done};
    endfunction

    always_comb begin
        state_next    = state_reg;
        pm25_tot_next = pm25_tot_reg;
        pm10_tot_next = pm10_tot_reg;
        count_next    = count_reg;
        avg25_next    = avg25_reg;
        odata_next    = odata_reg;
        ovalid_next   = ovalid_reg && !m_tready;
        dreq.start    = 1'b0;
        dreq.dividend = pm25_tot_reg;
        dreq.divisor  = count_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (mode)
                        MODE_RX: begin
                            if (evt.ok && (count_reg != COUNT_MAX)) begin
                                pm25_tot_next = pm25_tot_reg + {16'd0, evt.pm25};
                                pm10_tot_next = pm10_tot_reg + {16'd0, evt.pm10};
                                count_next    = count_reg + 1'b1;
                            end
                            ovalid_next = 1'b1;
                            odata_next  = pack_result(evt.done, evt.ok, 16'd0, 16'd0,
                                                      count_next, 1'b0);
                        end
                        MODE_REPORT: begin
                            if (count_reg == 16'd0) begin
                                ovalid_next = 1'b1;
                                odata_next  = pack_result(1'b0, 1'b0, 16'd0, 16'd0,
                                                          16'd0, 1'b0);
                            end else begin
                                dreq.start = 1'b1;
                                state_next = ST_DIV25;
                            end
                        end
                        MODE_CLEAR: begin
                            pm25_tot_next = '0;
                            pm10_tot_next = '0;
                            count_next    = '0;
                            ovalid_next   = 1'b1;
                            odata_next    = pack_result(1'b0, 1'b0, 16'd0, 16'd0,
                                                        16'd0, 1'b0);
                        end
                        default: begin
                            // unused mode returns an all-zero result
                            ovalid_next = 1'b1;
                            odata_next  = pack_result(1'b0, 1'b0, 16'd0, 16'd0,
                                                      16'd0, 1'b0);
                        end
                    endcase
                end
            end
            ST_DIV25: begin
                if (dstat.done) begin
                    avg25_next    = dstat.quotient;
                    dreq.start    = 1'b1;
                    dreq.dividend = pm10_tot_reg;
                    state_next    = ST_DIV10;
                end
            end
            ST_DIV10: begin
                // output register is empty here, it drained when the report was taken
                if (dstat.done) begin
                    ovalid_next = 1'b1;
                    odata_next  = pack_result(1'b0, 1'b0, avg25_reg, dstat.quotient,
                                              count_reg, 1'b1);
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pm25_tot_reg <= '0;
            pm10_tot_reg <= '0;
            count_reg    <= '0;
            ovalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pm25_tot_reg <= pm25_tot_next;
            pm10_tot_reg <= pm10_tot_next;
            count_reg    <= count_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        avg25_reg <= avg25_next;
        odata_reg <= odata_next;
    end

endmodule

// ===== sv/pmsfa_framer.sv =====
// ----------------------------------------------------------------------------
// pmsfa_framer
// Counts bytes into fixed-length frames, keeps the running byte sum and
// captures the big-endian PM2.5 and PM10 fields.
// ----------------------------------------------------------------------------
module pmsfa_framer
    import pmsfa_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       rx_valid,
    input  logic [7:0] rx_byte,
    output frame_evt_t evt
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [7:0]       sum_reg,  sum_next;
    logic [15:0]      pm25_reg, pm25_next;
    logic [15:0]      pm10_reg, pm10_next;
    logic [7:0]       sum_upd;
    logic             last;

    assign sum_upd = sum_reg + rx_byte;
    assign last    = (pos_reg >= LAST_POS);

    always_comb begin
        pm25_next = pm25_reg;
        pm10_next = pm10_reg;
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        if (rx_valid) begin
            unique case (pos_reg)
                PM25_HI_POS: pm25_next = {rx_byte, pm25_reg[7:0]};
                PM25_LO_POS: pm25_next = {pm25_reg[15:8], rx_byte};
                PM10_HI_POS: pm10_next = {rx_byte, pm10_reg[7:0]};
                PM10_LO_POS: pm10_next = {pm10_reg[15:8], rx_byte};
                default: ;
            endcase
            if (last) begin
                pos_next = '0;
                sum_next = '0;
            end else begin
                pos_next = pos_reg + 1'b1;
                sum_next = sum_upd;
            end
        end
    end

    // captures include the current byte, a short frame may end on a pm field
    assign evt.done = rx_valid && last;
    assign evt.ok   = rx_valid && last && (sum_upd == 8'd0);
    assign evt.pm25 = pm25_next;
    assign evt.pm10 = pm10_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            pm25_reg <= '0;
            pm10_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            pm25_reg <= pm25_next;
            pm10_reg <= pm10_next;
        end
    end

endmodule

// ===== sv/pmsfa_div.sv =====
// ----------------------------------------------------------------------------
// pmsfa_div
// Radix-2 restoring divider, 32 by 16 bits with a 16-bit quotient, one
// quotient bit per cycle. The dividend's upper half must be below the divisor.
// ----------------------------------------------------------------------------
module pmsfa_div
    import pmsfa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  div_req_t  req,
    output div_stat_t stat
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [15:0]      rem_reg,  rem_next;
    logic [15:0]      quo_reg,  quo_next;
    logic [15:0]      dvs_reg,  dvs_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             done_reg, done_next;
    logic [16:0]      partial;
    logic [17:0]      trial;

    assign partial = {rem_reg, quo_reg[15]};
    assign trial   = {1'b0, partial} - {2'b00, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next = req.dividend[31:16];
            quo_next = req.dividend[15:0];
            dvs_next = req.divisor;
            cnt_next = CNT_W'(DIV_STEPS);
        end else if (cnt_reg != '0) begin
            if (!trial[17]) begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[14:0], 1'b1};
            end else begin
                rem_next = partial[15:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

// ===== tb/sv/pm_sensor_frame_accumulator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pm_sensor_frame_accumulator_tb
// Streams sensor bytes, report, clear and unused requests into the frame
// accumulator and checks every result against an in-bench model of the
// framer, checksum, totals and averages, under random source and sink stalls.
// ----------------------------------------------------------------------------
module pm_sensor_frame_accumulator_tb;
    import pmsfa_pkg::*;

    localparam int         FRAME_LEN   = FRAME_LEN_DEFAULT;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         MAX_PRINTS  = 20;
    localparam int         DRAIN_WAIT  = 60;

    typedef struct {
        logic        done;
        logic        ok;
        logic [15:0] pm25_avg;
        logic [15:0] pm10_avg;
        logic [15:0] count;
        logic        avg_valid;
    } sensor_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [1:0]  s_tuser  = MODE_RX;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    // model state
    logic [POS_W-1:0] pos_q;
    logic [7:0]       csum_q;
    logic [15:0]      cap25_q;
    logic [15:0]      cap10_q;
    logic [31:0]      tot25_q;
    logic [31:0]      tot10_q;
    logic [15:0]      cnt_q;

    sensor_result_t expected_results[$];
    logic [7:0]     frame_buf [FRAME_LEN];

    int  n_mismatches = 0;
    int  n_requests   = 0;
    int  n_frames     = 0;
    int  n_good       = 0;
    int  n_reports    = 0;
    int  burst_left   = 0;
    int  hold_left    = 0;
    bit  full_rate    = 1'b0;

    pm_sensor_frame_accumulator #(
        .FRAME_LEN(FRAME_LEN)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic sensor_result_t predict_result(logic [1:0] mode, logic [7:0] b);
        sensor_result_t r;
        r = '{done: 1'b0, ok: 1'b0, pm25_avg: 16'd0, pm10_avg: 16'd0,
              count: 16'd0, avg_valid: 1'b0};
        case (mode)
            MODE_RX: begin
                csum_q = csum_q + b;
                if (pos_q == PM25_HI_POS) cap25_q[15:8] = b;
                else if (pos_q == PM25_LO_POS) cap25_q[7:0] = b;
                else if (pos_q == PM10_HI_POS) cap10_q[15:8] = b;
                else if (pos_q == PM10_LO_POS) cap10_q[7:0] = b;
                if (int'(pos_q) + 1 >= FRAME_LEN) begin
                    r.done = 1'b1;
                    r.ok   = (csum_q == 8'h00);
                    n_frames++;
                    if (r.ok) n_good++;
                    // saturated count freezes the totals too
                    if (r.ok && cnt_q != COUNT_MAX) begin
                        tot25_q = tot25_q + {16'd0, cap25_q};
                        tot10_q = tot10_q + {16'd0, cap10_q};
                        cnt_q   = cnt_q + 16'd1;
                    end
                    pos_q  = '0;
                    csum_q = 8'h00;
                end else begin
                    pos_q = pos_q + 1'b1;
                end
                r.count = cnt_q;
            end
            MODE_REPORT: begin
                n_reports++;
                if (cnt_q != 16'd0) begin
                    r.pm25_avg  = 16'(tot25_q / {16'd0, cnt_q});
                    r.pm10_avg  = 16'(tot10_q / {16'd0, cnt_q});
                    r.avg_valid = 1'b1;
                end
                r.count = cnt_q;
            end
            MODE_CLEAR: begin
                // frame in progress survives a clear
                tot25_q = 32'd0;
                tot10_q = 32'd0;
                cnt_q   = 16'd0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (n_mismatches < MAX_PRINTS)
            $display("mismatch at %0t: %s got 0x%0h expected 0x%0h",
                     $realtime, what, got, want);
        n_mismatches++;
    endtask

    task automatic send_req(input logic [1:0] mode, input logic [7:0] data);
        int gap;
        if (!full_rate && burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(0, 3);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (burst_left > 0) burst_left--;
        n_requests++;
        expected_results.push_back(predict_result(mode, data));
    endtask

    // fill frame_buf with random filler, the pm fields and a zero-sum last byte
    function automatic void fill_frame(logic [15:0] pm25, logic [15:0] pm10);
        logic [7:0] sum;
        sum = 8'h00;
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            if (i == PM25_HI_POS) frame_buf[i] = pm25[15:8];
            else if (i == PM25_LO_POS) frame_buf[i] = pm25[7:0];
            else if (i == PM10_HI_POS) frame_buf[i] = pm10[15:8];
            else if (i == PM10_LO_POS) frame_buf[i] = pm10[7:0];
            else frame_buf[i] = 8'($urandom);
            sum = sum + frame_buf[i];
        end
        frame_buf[FRAME_LEN-1] = 8'h00 - sum;
    endfunction

    function automatic void fill_frame_checksum();
        logic [7:0] sum;
        sum = 8'h00;
        for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum + frame_buf[i];
        frame_buf[FRAME_LEN-1] = 8'h00 - sum;
    endfunction

    function automatic logic [15:0] pick_pm();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(0, 200));
            default: return 16'($urandom);
        endcase
    endfunction

    // random frame, optionally corrupted, optionally with stray requests mixed in
    task automatic send_frame(input bit corrupt, input bit interleave);
        fill_frame(pick_pm(), pick_pm());
        if (corrupt)
            frame_buf[$urandom_range(0, FRAME_LEN - 1)] += 8'($urandom_range(1, 255));
        for (int i = 0; i < FRAME_LEN; i++) begin
            if (interleave && $urandom_range(0, 29) == 0)
                send_req(2'($urandom_range(1, 3)), 8'($urandom));
            send_req(MODE_RX, frame_buf[i]);
        end
    endtask

    // sink: ready and stall runs of random length
    always @(posedge aclk) begin
        if (full_rate) begin
            m_tready <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else begin
            m_tready  <= ~m_tready;
            if (m_tready)
                hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50)
                                                         : $urandom_range(0, 6);
            else
                hold_left <= $urandom_range(0, 20);
        end
    end

    always @(posedge aclk) begin
        sensor_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 32'(m_tdata), 32'd0);
            end else begin
                e = expected_results.pop_front();
                if (m_tdata[0] !== e.done)
                    report_mismatch("frame_done", 32'(m_tdata[0]), 32'(e.done));
                if (m_tdata[1] !== e.ok)
                    report_mismatch("frame_ok", 32'(m_tdata[1]), 32'(e.ok));
                if (m_tdata[17:2] !== e.pm25_avg)
                    report_mismatch("pm25_average", 32'(m_tdata[17:2]), 32'(e.pm25_avg));
                if (m_tdata[33:18] !== e.pm10_avg)
                    report_mismatch("pm10_average", 32'(m_tdata[33:18]), 32'(e.pm10_avg));
                if (m_tdata[49:34] !== e.count)
                    report_mismatch("frames_counted", 32'(m_tdata[49:34]), 32'(e.count));
                if (m_tdata[50] !== e.avg_valid)
                    report_mismatch("average_valid", 32'(m_tdata[50]), 32'(e.avg_valid));
                if (m_tdata[55:51] !== 5'd0)
                    report_mismatch("padding", 32'(m_tdata[55:51]), 32'd0);
            end
        end
    end

    // empty accumulators: zero-count report, unused mode, clear
    task automatic test_reset_state();
        send_req(MODE_REPORT, 8'hFF);
        send_req(MODE_UNUSED, 8'hA5);
        send_req(MODE_CLEAR, 8'h00);
    endtask

    // one frame with extreme bytes and requests cutting into it
    task automatic test_directed_frame();
        fill_frame(16'hFFFF, 16'h0000);
        for (int i = 0; i < FRAME_LEN - 1; i++)
            if (i != PM25_HI_POS && i != PM25_LO_POS && i != PM10_HI_POS && i != PM10_LO_POS)
                frame_buf[i] = (i % 2 == 0) ? 8'hFF : 8'h00;
        fill_frame_checksum();
        for (int i = 0; i < FRAME_LEN; i++) begin
            if (i == 3) send_req(MODE_REPORT, 8'h00);
            if (i == 8) send_req(MODE_CLEAR, 8'hFF);
            if (i == 12) send_req(MODE_UNUSED, 8'h00);
            send_req(MODE_RX, frame_buf[i]);
        end
        send_req(MODE_REPORT, 8'h00);
    endtask

    // mostly aligned frames, with bad sums, reports, clears, unused requests and stray bytes
    task automatic test_random_traffic();
        int start;
        int r;
        start = n_requests;
        while (n_requests - start < 270) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                // pad out a partial frame so the next one lands aligned
                while (pos_q != '0) send_req(MODE_RX, 8'($urandom));
                send_frame(r >= 70, 1'b1);
            end else if (r < 88) begin
                send_req(MODE_REPORT, 8'($urandom));
            end else if (r < 92) begin
                send_req(MODE_CLEAR, 8'($urandom));
            end else if (r < 95) begin
                send_req(MODE_UNUSED, 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 3)) send_req(MODE_RX, 8'($urandom));
            end
        end
        while (pos_q != '0) send_req(MODE_RX, 8'($urandom));
        send_req(MODE_REPORT, 8'h00);
    endtask

    // back-to-back frames and reports with no source gaps and no sink stalls, then more under stalls
    task automatic test_full_rate();
        full_rate = 1'b1;
        send_req(MODE_CLEAR, 8'h00);
        for (int i = 0; i < 3; i++) begin
            fill_frame(16'hFFFF, 16'($urandom));
            for (int k = 0; k < FRAME_LEN; k++) send_req(MODE_RX, frame_buf[k]);
        end
        send_req(MODE_REPORT, 8'h00);
        send_req(MODE_REPORT, 8'h00);
        full_rate = 1'b0;
        send_frame(1'b1, 1'b0);
        send_frame(1'b0, 1'b0);
        send_req(MODE_REPORT, 8'h00);
        send_req(MODE_CLEAR, 8'h00);
        send_req(MODE_REPORT, 8'h00);
    endtask

    initial begin
        pos_q   = '0;
        csum_q  = 8'h00;
        cap25_q = 16'd0;
        cap10_q = 16'd0;
        tot25_q = 32'd0;
        tot10_q = 32'd0;
        cnt_q   = 16'd0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_directed_frame();
        test_random_traffic();
        test_full_rate();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("sent %0d requests: %0d frames completed, %0d with a good sum, %0d reports",
                 n_requests, n_frames, n_good, n_reports);
        $display("back-to-back frames, bad sums, clears mid-frame and unused mode included");
        if (n_mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", n_mismatches);
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(64'd5_000_000);
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("FAIL");
        $finish;
    end

endmodule
